### rtl/core/rqts_pkg.sv
package rqts_pkg;

  localparam int NUM_TASKS      = 16;
  localparam int NUM_PRIORITIES = 4;
  localparam int AGE_DIVISOR    = 1024;

  localparam int TASK_W  = 4;
  localparam int COUNT_W = 5;
  localparam int PRIO_W  = 2;
  localparam int MASK_W  = 2;
  localparam int TICK_W  = 32;
  localparam int RANK_W  = 34;

  localparam logic [1:0] CMD_ENQUEUE  = 2'd0;
  localparam logic [1:0] CMD_SCHEDULE = 2'd1;
  localparam logic [1:0] CMD_SET_PRIO = 2'd2;
  localparam logic [1:0] CMD_SET_MASK = 2'd3;

  // per-task attribute word kept in one memory
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [PRIO_W-1:0] prio;
    logic [TICK_W-1:0] label;
  } task_attr_t;

  localparam int ATTR_W = $bits(task_attr_t);

  typedef struct packed {
    logic [1:0]        command;
    logic              core_id;
    logic [TASK_W-1:0] task_id;
    logic              keep_current;
    logic              stamp_now;
    logic [PRIO_W-1:0] priority_value;
    logic [MASK_W-1:0] mask_value;
    logic [TICK_W-1:0] now_ticks;
  } sched_cmd_t;

  typedef struct packed {
    logic [TASK_W-1:0] next_task;
    logic              affinity_refused;
    logic              queue_was_empty;
  } sched_res_t;

  // aged rank: priority*5 + age / AGE_DIVISOR (power of two, a shift)
  function automatic logic [RANK_W-1:0] aged_rank(input logic [PRIO_W-1:0] prio,
                                                   input logic [TICK_W-1:0] age);
    logic [RANK_W-1:0] p;
    logic [RANK_W-1:0] a;
    p = RANK_W'(prio) * RANK_W'(5);
    a = RANK_W'(age >> $clog2(AGE_DIVISOR));
    return p + a;
  endfunction

endpackage

### rtl/core/rqts_if.sv
interface rqts_cmd_if;
  import rqts_pkg::*;
  logic       valid;
  logic       ready;
  sched_cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rqts_res_if;
  import rqts_pkg::*;
  logic       valid;
  logic       ready;
  sched_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rqts_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/ready_queue_task_scheduler.sv
// Ready-queue task scheduler for two cores, one item at a time.
// Enqueue / set priority / set mask: S_ATTR_RD, S_ATTR_WR, ready again (a full ring drops an
// enqueue from S_ATTR_RD). Schedule in round robin, or in aging mode with one entry: S_PICK,
// attribute read/write, result; an empty ring goes straight to the result. Aging mode with
// count >= 2 scans every entry, then compacts those behind the pick. A stalled result waits.
// Reset (rst, synchronous) empties the ring, idles both cores, sweeps all 16 attributes.
module ready_queue_task_scheduler import rqts_pkg::*; (
  input logic         clk,
  input logic         rst,
  rqts_cmd_if.sink    cmd,
  rqts_res_if.source  res,
  rqts_cfg_if.sink    cfg
);

  localparam int IDX_W = $clog2(NUM_TASKS);

  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_ATTR_RD = 5'd2;
  localparam logic [4:0] S_ATTR_WR = 5'd3;
  localparam logic [4:0] S_SCAN_RD = 5'd4;
  localparam logic [4:0] S_SCAN_A  = 5'd5;
  localparam logic [4:0] S_SCAN_C  = 5'd6;
  localparam logic [4:0] S_PICK    = 5'd7;
  localparam logic [4:0] S_SHIFT_R = 5'd8;
  localparam logic [4:0] S_SHIFT_W = 5'd9;
  localparam logic [4:0] S_PATTR_R = 5'd10;
  localparam logic [4:0] S_PATTR_W = 5'd11;
  localparam logic [4:0] S_REQ     = 5'd12;
  localparam logic [4:0] S_OUT     = 5'd13;
  localparam logic [4:0] S_SCAN_W  = 5'd14;

  logic [4:0]         state;
  sched_cmd_t         op;
  logic               policy;
  logic [COUNT_W-1:0] count;
  logic [IDX_W-1:0]   head;
  logic [TASK_W-1:0]  running [2];
  logic [IDX_W-1:0]   sweep;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] best;
  logic [RANK_W-1:0]  best_rank;
  logic [TASK_W-1:0]  scan_task;
  logic [TASK_W-1:0]  pick;
  logic               refused;
  logic               empty;
  logic               out_valid;
  sched_res_t         out_data;

  // ring memory
  logic               ring_we;
  logic [IDX_W-1:0]   ring_wa;
  logic [TASK_W-1:0]  ring_wd;
  logic [IDX_W-1:0]   ring_ra;
  logic [TASK_W-1:0]  ring_rd;

  // attribute memory
  logic               attr_we;
  logic [IDX_W-1:0]   attr_wa;
  task_attr_t         attr_wd;
  logic [IDX_W-1:0]   attr_ra;
  task_attr_t         attr_rd;

  rqts_ram #(.WIDTH(TASK_W), .DEPTH(NUM_TASKS)) u_ring (
    .clk(clk), .we(ring_we), .waddr(ring_wa), .wdata(ring_wd),
    .raddr(ring_ra), .rdata(ring_rd)
  );

  rqts_ram #(.WIDTH(ATTR_W), .DEPTH(NUM_TASKS)) u_attr (
    .clk(clk), .we(attr_we), .waddr(attr_wa), .wdata(attr_wd),
    .raddr(attr_ra), .rdata(attr_rd)
  );

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign res.valid = out_valid;
  assign res.data  = out_data;

  // ring slot at offset i from head
  function automatic logic [IDX_W-1:0] pos(input logic [IDX_W-1:0] h,
                                           input logic [COUNT_W-1:0] i);
    return h + i[IDX_W-1:0];
  endfunction

  logic [TICK_W-1:0]  scan_age;
  logic [RANK_W-1:0]  scan_rank;
  logic               full;
  logic               push_cur;
  logic [COUNT_W-1:0] scan_next;
  assign scan_age  = op.now_ticks - attr_rd.label;
  assign scan_rank = aged_rank(attr_rd.prio, scan_age);
  assign full      = (count == COUNT_W'(NUM_TASKS));
  assign push_cur  = op.keep_current && (running[op.core_id] != '0);

  // ring entry wanted after the compare: next entry, or the winner on the last one
  assign scan_next = (idx + COUNT_W'(1) == count) ?
                     ((scan_rank > best_rank) ? idx : best) : idx + COUNT_W'(1);

  // memory port steering
  always_comb begin
    ring_we = 1'b0;
    ring_wa = pos(head, count);
    ring_wd = op.task_id;
    ring_ra = pos(head, idx);
    attr_we = 1'b0;
    attr_wa = op.task_id;
    attr_wd = attr_rd;
    attr_ra = op.task_id;
    unique case (state)
      S_INIT: begin
        attr_we = 1'b1;
        attr_wa = sweep;
        attr_wd = '{mask: '1, prio: '0, label: '0};
      end
      S_IDLE: begin
        attr_ra = cmd.data.task_id;
      end
      S_ATTR_WR: begin
        attr_we = 1'b1;
        unique case (op.command)
          CMD_ENQUEUE: begin
            attr_we = op.stamp_now;
            attr_wd.label = op.now_ticks;
          end
          CMD_SET_PRIO: attr_wd.prio = op.priority_value;
          CMD_SET_MASK: attr_wd.mask = op.mask_value;
          default: attr_we = 1'b0;
        endcase
        ring_we = (op.command == CMD_ENQUEUE);
      end
      S_SCAN_A: attr_ra = ring_rd;
      S_SCAN_W: attr_ra = scan_task;
      S_SCAN_C: begin
        attr_ra = scan_task;
        ring_ra = pos(head, scan_next);
      end
      S_SHIFT_R: ring_ra = pos(head, idx + COUNT_W'(1));
      S_SHIFT_W: begin
        ring_we = 1'b1;
        ring_wa = pos(head, idx);
        ring_wd = ring_rd;
      end
      S_PICK: attr_ra = ring_rd;
      S_PATTR_R: attr_ra = pick;
      S_PATTR_W: begin
        attr_ra = pick;
        attr_we = policy;
        attr_wa = pick;
        attr_wd.label = op.now_ticks;
      end
      S_REQ: begin
        ring_we = refused && !full;
        ring_wd = pick;
      end
      S_OUT: begin
        ring_we = push_cur && !full;
        ring_wd = running[op.core_id];
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      policy     <= 1'b0;
      count      <= '0;
      head       <= '0;
      running[0] <= '0;
      running[1] <= '0;
      sweep      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        policy <= cfg.data;
      end
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          sweep <= sweep + IDX_W'(1);
          if (sweep == IDX_W'(NUM_TASKS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            op    <= cmd.data;
            idx   <= '0;
            if (cmd.data.command == CMD_SCHEDULE) begin
              empty <= (count == '0);
              refused <= 1'b0;
              best <= '0;
              best_rank <= '0;
              state <= (count == '0) ? S_OUT : S_SCAN_RD;
            end else begin
              state <= S_ATTR_RD;
            end
          end
        end
        S_ATTR_RD: begin
          if (op.command == CMD_ENQUEUE && full) begin
            state <= S_IDLE;
          end else begin
            state <= S_ATTR_WR;
          end
        end
        S_ATTR_WR: begin
          if (op.command == CMD_ENQUEUE) begin
            count <= count + COUNT_W'(1);
          end
          state <= S_IDLE;
        end
        // ring read address settles on idx
        S_SCAN_RD: begin
          state <= (policy && count != COUNT_W'(1)) ? S_SCAN_A : S_PICK;
          idx   <= policy ? idx : best;
        end
        S_SCAN_A: begin
          scan_task <= ring_rd;
          state     <= S_SCAN_W;
        end
        S_SCAN_W: state <= S_SCAN_C;
        S_SCAN_C: begin
          if (scan_rank > best_rank) begin
            best_rank <= scan_rank;
            best      <= idx;
          end
          if (idx + COUNT_W'(1) == count) begin
            idx   <= (scan_rank > best_rank) ? idx : best;
            state <= S_PICK;
          end else begin
            idx   <= idx + COUNT_W'(1);
            state <= S_SCAN_A;
          end
        end
        S_PICK: begin
          pick  <= ring_rd;
          state <= S_SHIFT_R;
          if (!policy) begin
            head  <= head + IDX_W'(1);
            count <= count - COUNT_W'(1);
            state <= S_PATTR_R;
          end else if (idx + COUNT_W'(1) >= count) begin
            count <= count - COUNT_W'(1);
            state <= S_PATTR_R;
          end
        end
        S_SHIFT_R: state <= S_SHIFT_W;
        S_SHIFT_W: begin
          if (idx + COUNT_W'(2) >= count) begin
            count <= count - COUNT_W'(1);
            state <= S_PATTR_R;
          end else begin
            idx   <= idx + COUNT_W'(1);
            state <= S_SHIFT_R;
          end
        end
        S_PATTR_R: state <= S_PATTR_W;
        S_PATTR_W: begin
          refused <= !attr_rd.mask[op.core_id];
          state   <= S_REQ;
        end
        S_REQ: begin
          if (refused && !full) begin
            count <= count + COUNT_W'(1);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || res.ready) begin
            if (push_cur && !full) begin
              count <= count + COUNT_W'(1);
            end
            running[op.core_id] <= (empty || refused) ? '0 : pick;
            out_valid <= 1'b1;
            out_data  <= '{next_task: (empty || refused) ? '0 : pick,
                           affinity_refused: refused,
                           queue_was_empty: empty};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/rqts_ram.sv
module rqts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### tb/sv/ready_queue_task_scheduler_tb.sv
module ready_queue_task_scheduler_tb;
  import rqts_pkg::*;

  logic clk;
  logic rst;

  rqts_cmd_if cmd_ch();
  rqts_res_if res_ch();
  rqts_cfg_if cfg_ch();

  ready_queue_task_scheduler dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 60;
  localparam int LONG_HOLD   = 400;

  typedef struct {
    sched_cmd_t c;
    bit         typed;
    sched_res_t r;
  } stim_row_t;

  // scheduler shadow state
  logic [TASK_W-1:0] ring_q [NUM_TASKS];
  int                ring_cnt;
  int                ring_hd;
  logic [MASK_W-1:0] sh_mask [NUM_TASKS];
  logic [PRIO_W-1:0] sh_prio [NUM_TASKS];
  logic [TICK_W-1:0] sh_label [NUM_TASKS];
  logic [TASK_W-1:0] sh_running [2];
  logic              sh_mode;

  sched_res_t  dispatch_q [$];
  stim_row_t   stim_rows [$];
  int          errors;
  int          cycles;
  int          hold_req;
  int          hold_seen;
  int          stall_left;
  logic [31:0] tick;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ready_queue_task_scheduler: mismatch");
      $finish;
    end
  end

  function automatic int slot(int i);
    return (ring_hd + i) % NUM_TASKS;
  endfunction

  function automatic void ring_append(logic [TASK_W-1:0] t);
    if (ring_cnt < NUM_TASKS) begin
      ring_q[slot(ring_cnt)] = t;
      ring_cnt++;
    end
  endfunction

  function automatic logic [63:0] rank_of(logic [TASK_W-1:0] t, logic [TICK_W-1:0] now);
    logic [TICK_W-1:0] age;
    age = now - sh_label[t];
    return 64'(sh_prio[t]) * 64'd5 + 64'(age / AGE_DIVISOR);
  endfunction

  // advance shadow state by one command; returns 1 when a dispatch result is due
  function automatic bit predict_dispatch(input sched_cmd_t c, output sched_res_t r);
    logic [TASK_W-1:0] cur;
    logic [TASK_W-1:0] pick;
    logic [63:0]       best_rank;
    logic [63:0]       rk;
    int                best;
    r = '0;
    case (c.command)
      CMD_ENQUEUE: begin
        if (ring_cnt < NUM_TASKS) begin
          ring_append(c.task_id);
          if (c.stamp_now) sh_label[c.task_id] = c.now_ticks;
        end
        return 1'b0;
      end
      CMD_SET_PRIO: begin
        sh_prio[c.task_id] = c.priority_value;
        return 1'b0;
      end
      CMD_SET_MASK: begin
        sh_mask[c.task_id] = c.mask_value;
        return 1'b0;
      end
      default: begin
        cur = sh_running[c.core_id];
        r.queue_was_empty = (ring_cnt == 0);
        if (ring_cnt != 0) begin
          if (!sh_mode) begin
            pick = ring_q[slot(0)];
            ring_hd = slot(1);
            ring_cnt--;
          end else begin
            best = 0;
            best_rank = '0;
            for (int i = 0; i < ring_cnt; i++) begin
              rk = rank_of(ring_q[slot(i)], c.now_ticks);
              if (rk > best_rank) begin
                best_rank = rk;
                best = i;
              end
            end
            pick = ring_q[slot(best)];
            for (int i = best; i + 1 < ring_cnt; i++) ring_q[slot(i)] = ring_q[slot(i + 1)];
            ring_cnt--;
            sh_label[pick] = c.now_ticks;
          end
          if (!sh_mask[pick][c.core_id]) begin
            ring_append(pick);
            r.affinity_refused = 1'b1;
          end else begin
            r.next_task = pick;
          end
        end
        if (c.keep_current && cur != '0) ring_append(cur);
        sh_running[c.core_id] = r.next_task;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic sched_cmd_t mk(logic [1:0] op, logic core, logic [3:0] tid, logic keep,
                                    logic stamp, logic [1:0] prio, logic [1:0] mask,
                                    logic [31:0] now);
    sched_cmd_t c;
    c.command = op;
    c.core_id = core;
    c.task_id = tid;
    c.keep_current = keep;
    c.stamp_now = stamp;
    c.priority_value = prio;
    c.mask_value = mask;
    c.now_ticks = now;
    return c;
  endfunction

  function automatic void add(sched_cmd_t c, bit typed = 1'b0, logic [3:0] nt = '0,
                              logic rf = 1'b0, logic em = 1'b0);
    stim_row_t row;
    row.c = c;
    row.typed = typed;
    row.r.next_task = nt;
    row.r.affinity_refused = rf;
    row.r.queue_was_empty = em;
    stim_rows.push_back(row);
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one command transfer; updates the prediction at acceptance
  task automatic send_cmd(input sched_cmd_t c, input bit typed, input sched_res_t tr);
    sched_res_t pr;
    bit         due;
    int         g;
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    do @(posedge clk); while (!cmd_ch.ready);
    due = predict_dispatch(c, pr);
    if (due) dispatch_q.push_back(typed ? tr : pr);
    g = gap_len();
    if (g > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (dispatch_q.size() != 0) @(posedge clk);
  endtask

  // mode register write, only with the block idle
  task automatic write_mode(input logic m);
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sh_mode = m;
  endtask

  function automatic sched_cmd_t rand_cmd();
    sched_cmd_t  c;
    logic [63:0] raw;
    int p;
    p = $urandom_range(0, 99);
    if (p < 5) tick = $urandom;
    else tick = tick + $urandom_range(0, 4000);
    raw = {$urandom, $urandom};
    c = raw[$bits(sched_cmd_t)-1:0];
    c.now_ticks = tick;
    p = $urandom_range(0, 99);
    if (p < 40) c.command = CMD_ENQUEUE;
    else if (p < 72) c.command = CMD_SCHEDULE;
    else if (p < 86) c.command = CMD_SET_PRIO;
    else c.command = CMD_SET_MASK;
    // mostly usable masks so that tasks actually run
    if (c.command == CMD_SET_MASK && $urandom_range(0, 2) != 0) c.mask_value = 2'd3;
    return c;
  endfunction

  // result side: check and randomized back-pressure
  always @(posedge clk) begin
    sched_res_t want;
    sched_res_t got;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (dispatch_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $realtime, got);
        end else begin
          want = dispatch_q.pop_front();
          if (got.next_task !== want.next_task) begin
            errors++;
            $display("%0t: next_task expected %0d actual %0d", $realtime,
                     want.next_task, got.next_task);
          end
          if (got.affinity_refused !== want.affinity_refused) begin
            errors++;
            $display("%0t: affinity_refused expected %0d actual %0d", $realtime,
                     want.affinity_refused, got.affinity_refused);
          end
          if (got.queue_was_empty !== want.queue_was_empty) begin
            errors++;
            $display("%0t: queue_was_empty expected %0d actual %0d", $realtime,
                     want.queue_was_empty, got.queue_was_empty);
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        stall_left <= LONG_HOLD;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        res_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 75) begin
        res_ch.ready <= 1'b1;
      end else begin
        stall_left <= gap_len();
        res_ch.ready <= 1'b0;
      end
    end
  end

  initial begin
    sched_res_t none;
    none = '0;
    errors = 0;
    cycles = 0;
    hold_req = 0;
    hold_seen = 0;
    stall_left = 0;
    tick = '0;
    ring_cnt = 0;
    ring_hd = 0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      ring_q[i] = '0;
      sh_mask[i] = 2'd3;
      sh_prio[i] = '0;
      sh_label[i] = '0;
    end
    sh_running[0] = '0;
    sh_running[1] = '0;
    sh_mode = 1'b0;
    clk = 1'b0;
    rst = 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows: empty ring, zero mask, extremes, full ring
    add(mk(CMD_SCHEDULE, 0, 0, 0, 0, 0, 0, 32'h0), 1, 0, 0, 1);
    add(mk(CMD_SCHEDULE, 1, 0, 1, 1, 3, 3, 32'hFFFF_FFFF), 1, 0, 0, 1);
    add(mk(CMD_SET_MASK, 0, 5, 0, 0, 0, 0, 32'h0));
    add(mk(CMD_ENQUEUE, 0, 5, 0, 1, 0, 0, 32'h0));
    add(mk(CMD_SCHEDULE, 0, 0, 0, 0, 0, 0, 32'h10), 1, 0, 1, 0);
    add(mk(CMD_SCHEDULE, 1, 0, 0, 0, 0, 0, 32'h20), 1, 0, 1, 0);
    add(mk(CMD_SET_MASK, 0, 5, 0, 0, 0, 3, 32'h0));
    add(mk(CMD_ENQUEUE, 1, 15, 1, 1, 3, 3, 32'hFFFF_FFFF));
    add(mk(CMD_SET_PRIO, 0, 15, 0, 0, 3, 0, 32'h0));
    add(mk(CMD_SCHEDULE, 0, 0, 0, 0, 0, 0, 32'h30), 1, 5, 0, 0);
    add(mk(CMD_SCHEDULE, 0, 0, 1, 0, 0, 0, 32'h40), 1, 15, 0, 0);
    add(mk(CMD_SET_MASK, 0, 15, 0, 0, 0, 2, 32'h0));
    add(mk(CMD_ENQUEUE, 0, 0, 0, 0, 0, 0, 32'h50));
    for (int t = 1; t < 15; t++) begin
      add(mk(CMD_ENQUEUE, 0, 4'(t), 0, 1'(t % 2), 0, 0, 32'h100 * t));
    end
    add(mk(CMD_ENQUEUE, 0, 9, 0, 1, 0, 0, 32'hABCD));
    add(mk(CMD_SCHEDULE, 1, 0, 1, 0, 0, 0, 32'h60));
    add(mk(CMD_SCHEDULE, 0, 0, 1, 0, 0, 0, 32'h70));
    foreach (stim_rows[i]) send_cmd(stim_rows[i].c, stim_rows[i].typed, stim_rows[i].r);

    // random phases over both policies
    for (int ph = 0; ph < 4; ph++) begin
      write_mode((ph % 2) == 0);
      for (int n = 0; n < 500; n++) begin
        if (ph == 1 && n == 100) hold_req <= hold_req + 1;
        if (ph == 2 && n == 250) drain();
        send_cmd(rand_cmd(), 1'b0, none);
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && dispatch_q.size() == 0) begin
      $display("ready_queue_task_scheduler: match");
    end else begin
      $display("ready_queue_task_scheduler: mismatch");
    end
    $finish;
  end

endmodule
